### sv/rbd_pkg.sv
// Shared constants, register codes and types for the 2x2 RGBA box downsampler.
`timescale 1ns / 1ps

package rbd_pkg;

    // Default and fixed image limits
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;

    // Field widths
    localparam int CH_W   = 8;              // one color channel
    localparam int PAIR_W = CH_W + 1;       // sum of two channel bytes
    localparam int QUAD_W = CH_W + 2;       // sum of four channel bytes
    localparam int NUM_CH = 4;
    localparam int LINE_W = NUM_CH * PAIR_W; // one line store entry
    localparam int DIM_W  = 13;             // config register width
    localparam int ROW_W  = 12;             // row counter, rows < MAX_HEIGHT
    localparam int IDX_W  = 1;              // config register index

    // Config register indexes
    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

    // What the scan position says about the pixel being accepted
    typedef struct packed {
        logic take_left;   // even column inside the active area: hold pixel
        logic write_pair;  // odd column, even row: store pair sums
        logic emit;        // odd column, odd row: produce an output pixel
        logic last;        // this output pixel closes the reduced image
    } rbd_step_t;

endpackage

### sv/rbd_line_ram.sv
// Line store of pair sums: one write port, one registered read port.
`timescale 1ns / 1ps

module rbd_line_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 36
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/rbd_scan.sv
// Config registers and raster scan counters; decode what each pixel does.
`timescale 1ns / 1ps

module rbd_scan #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = 12,
    parameter int CW        = 13,
    parameter int AW        = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [rbd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rbd_pkg::DIM_W-1:0]   cfg_data,
    input  logic                        advance,
    output rbd_pkg::rbd_step_t          step,
    output logic [AW-1:0]               slot
);

    localparam int DW    = (CW > rbd_pkg::DIM_W) ? CW : rbd_pkg::DIM_W;
    localparam int W_RST = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam int HW    = rbd_pkg::DIM_W;

    logic [CW-1:0]               width_reg;
    logic [HW-1:0]               height_reg;
    logic [COL_W-1:0]            col_reg;
    logic [rbd_pkg::ROW_W-1:0]   row_reg;

    logic [DW-1:0]               wr_val;
    logic [CW-1:0]               width_clamped;
    logic [HW-1:0]               height_clamped;
    logic [CW-1:0]               width_even;
    logic [HW-1:0]               height_even;
    logic [CW-1:0]               col_inc;
    logic [HW-1:0]               row_inc;
    logic                        active;
    logic [COL_W-1:0]            col_next;
    logic [rbd_pkg::ROW_W-1:0]   row_next;

    // Clamp widths to [2, MAX_WIDTH] and heights to [2, MAX_HEIGHT] at write
    always_comb
    begin
        wr_val = DW'(cfg_data);
        if (wr_val < DW'(2))
        begin
            width_clamped = CW'(2);
        end
        else if (wr_val > DW'(MAX_WIDTH))
        begin
            width_clamped = CW'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = CW'(wr_val);
        end

        if (cfg_data < HW'(2))
        begin
            height_clamped = HW'(2);
        end
        else if (cfg_data > HW'(rbd_pkg::MAX_HEIGHT))
        begin
            height_clamped = HW'(rbd_pkg::MAX_HEIGHT);
        end
        else
        begin
            height_clamped = cfg_data;
        end
    end

    assign width_even  = {width_reg[CW-1:1], 1'b0};
    assign height_even = {height_reg[HW-1:1], 1'b0};
    assign col_inc     = CW'(col_reg) + CW'(1);
    assign row_inc     = HW'(row_reg) + HW'(1);
    assign active      = (CW'(col_reg) < width_even) && (HW'(row_reg) < height_even);

    always_comb
    begin
        step.take_left  = active && !col_reg[0];
        step.write_pair = active && col_reg[0] && !row_reg[0];
        step.emit       = active && col_reg[0] && row_reg[0];
        step.last       = (col_inc == width_even) && (row_inc == height_even);
    end

    assign slot = AW'(col_reg >> 1);

    // Advance the raster position, wrapping at row and frame end
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= width_reg)
        begin
            col_next = '0;
            if (row_inc >= height_reg)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = rbd_pkg::ROW_W'(row_inc);
            end
        end
        else
        begin
            col_next = COL_W'(col_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CW'(W_RST);
            height_reg <= HW'(rbd_pkg::MAX_HEIGHT);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rbd_pkg::REG_SRC_WIDTH:  width_reg  <= width_clamped;
                rbd_pkg::REG_SRC_HEIGHT: height_reg <= height_clamped;
                default:                 width_reg  <= width_reg;
            endcase
            // Any write restarts the frame
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### sv/rgba_box_downsample_2x2.sv
// Top level of the 2x2 box-filter RGBA mipmap downsampler.
// Throughput: one source pixel per cycle, with no gaps while out_stall stays low.
// Path: an accepted odd-row, odd-column pixel is taken into the line store read
//   register and stage 1, then into the result register, which raises out_valid.
// Reset: asynchronous, active low; width and height return to 4096 (clamped
//   to MAX_WIDTH), the scan restarts at pixel (0,0), the pipeline empties.
`timescale 1ns / 1ps

module rgba_box_downsample_2x2 #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Config write port
    input  logic                          cfg_write,
    input  logic [rbd_pkg::IDX_W-1:0]     cfg_index,
    input  logic [rbd_pkg::DIM_W-1:0]     cfg_data,

    // Source pixel channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rbd_pkg::CH_W-1:0]      red_in,
    input  logic [rbd_pkg::CH_W-1:0]      green_in,
    input  logic [rbd_pkg::CH_W-1:0]      blue_in,
    input  logic [rbd_pkg::CH_W-1:0]      alpha_in,

    // Reduced pixel channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rbd_pkg::CH_W-1:0]      red_out,
    output logic [rbd_pkg::CH_W-1:0]      green_out,
    output logic [rbd_pkg::CH_W-1:0]      blue_out,
    output logic [rbd_pkg::CH_W-1:0]      alpha_out,
    output logic                          frame_last
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int CH_W  = rbd_pkg::CH_W;
    localparam int PW    = rbd_pkg::PAIR_W;
    localparam int QW    = rbd_pkg::QUAD_W;
    localparam int NCH   = rbd_pkg::NUM_CH;
    localparam int LW    = rbd_pkg::LINE_W;

    rbd_pkg::rbd_step_t    step;
    logic [AW-1:0]         slot;
    logic                  in_accept;
    logic                  s1_move;

    logic [NCH*CH_W-1:0]   pix;
    logic [NCH*CH_W-1:0]   left_reg;
    logic [LW-1:0]         pair_sum;
    logic [LW-1:0]         line_data;

    // Stage 1: bottom-row pair sums wait here next to the line store read
    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic [LW-1:0]         s1_pair_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic [NCH*CH_W-1:0]   out_pix_reg;
    logic [NCH*CH_W-1:0]   out_pix_next;

    // Stage 1 moves on when the result register is empty or being drained;
    // hold the source side only while stage 1 is full and cannot move.
    assign s1_move   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    assign pix = {alpha_in, blue_in, green_in, red_in};

    rbd_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .CW        (CW),
        .AW        (AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_accept),
        .step      (step),
        .slot      (slot)
    );

    // Horizontal pair sums of the held left pixel and the arriving right one
    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            pair_sum[k*PW +: PW] = PW'(left_reg[k*CH_W +: CH_W]) + PW'(pix[k*CH_W +: CH_W]);
        end
    end

    // Hold the even-column pixel of each pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (in_accept && step.take_left)
        begin
            left_reg <= pix;
        end
    end

    // Even rows write pair sums; odd rows read the sums of the row above.
    // The two never touch one entry in the same cycle.
    rbd_line_ram #(
        .DEPTH   (DEPTH),
        .AW      (AW),
        .DW      (LW)
    ) u_line (
        .clk     (clk),
        .wr_en   (in_accept && step.write_pair),
        .wr_addr (slot),
        .wr_data (pair_sum),
        .rd_en   (in_accept && step.emit),
        .rd_addr (slot),
        .rd_data (line_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= step.emit;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && step.emit)
        begin
            s1_pair_reg <= pair_sum;
            s1_last_reg <= step.last;
        end
    end

    // Four-value sum, then drop the two low bits (divide by four, truncating)
    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            logic [QW-1:0] quad;
            quad = QW'(line_data[k*PW +: PW]) + QW'(s1_pair_reg[k*PW +: PW]);
            out_pix_next[k*CH_W +: CH_W] = quad[QW-1:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            out_pix_reg  <= out_pix_next;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = out_pix_reg[0*CH_W +: CH_W];
    assign green_out  = out_pix_reg[1*CH_W +: CH_W];
    assign blue_out   = out_pix_reg[2*CH_W +: CH_W];
    assign alpha_out  = out_pix_reg[3*CH_W +: CH_W];
    assign frame_last = out_last_reg;

endmodule

### dv/testbench.sv
// Self-checking testbench for the 2x2 RGBA box downsampler.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_CH        = rbd_pkg::NUM_CH;
    localparam int CH_W          = rbd_pkg::CH_W;
    localparam int PAIR_W        = rbd_pkg::PAIR_W;
    localparam int QUAD_W        = rbd_pkg::QUAD_W;
    localparam int IDX_W         = rbd_pkg::IDX_W;
    localparam int DIM_W         = rbd_pkg::DIM_W;
    localparam int MAX_WIDTH_DEF = rbd_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT    = rbd_pkg::MAX_HEIGHT;

    // Run shape
    localparam int RANDOM_ITEMS     = 330;
    localparam int PRESSURE_ITEMS   = 60;
    localparam int DRAIN_CYCLES     = 8;      // pipeline is two stages deep, leave margin
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RESET_CYCLES     = 10;

    // One pixel: index 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [NUM_CH-1:0][CH_W-1:0]   rgba_t;
    typedef logic [NUM_CH-1:0][PAIR_W-1:0] pair_entry_t;

    typedef struct packed {
        rgba_t rgba;
        logic  last;
    } reduced_t;

    // One row of the directed stimulus: a register write or a source pixel
    typedef struct packed {
        logic              is_cfg;
        logic [IDX_W-1:0]  idx;
        logic [DIM_W-1:0]  value;
        rgba_t             pix;
        logic              typed;
        reduced_t          want;
    } stim_row_t;

    typedef enum int {
        MODE_RECV_HEAVY,
        MODE_SEND_HEAVY,
        MODE_NO_IDLE
    } idle_mode_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [CH_W-1:0]   red_in;
    logic [CH_W-1:0]   green_in;
    logic [CH_W-1:0]   blue_in;
    logic [CH_W-1:0]   alpha_in;
    logic              out_valid;
    logic              out_stall;
    logic [CH_W-1:0]   red_out;
    logic [CH_W-1:0]   green_out;
    logic [CH_W-1:0]   blue_out;
    logic [CH_W-1:0]   alpha_out;
    logic              frame_last;

    // Predictor state: our own copy of the registers, scan position and line store
    int                cfg_width_q;
    int                cfg_height_q;
    int                scan_col;
    int                scan_row;
    rgba_t             left_hold;
    pair_entry_t       pair_line [MAX_WIDTH_DEF/2];

    reduced_t          expected_pixels [$];
    stim_row_t         directed_rows [$];

    int                send_idle_pct;
    int                recv_idle_pct;
    bit                long_hold_req;
    bit                long_hold_done;
    int                fail_count;

    rgba_box_downsample_2x2 u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .alpha_in   (alpha_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .frame_last (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops a result
    initial
    begin
        #1_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // Dimensions below 2 act as 2, above the limit act as the limit
    function automatic int clamp_dim(input int v, input int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the scan by one accepted pixel; report the reduced pixel it completes, if any
    task automatic predict_reduction(input rgba_t pix, output bit has_out, output reduced_t res);
        int                w;
        int                h;
        int                slot;
        pair_entry_t       entry;
        logic [QUAD_W-1:0] quad;
        has_out = 1'b0;
        res     = '0;
        w = clamp_dim(cfg_width_q, MAX_WIDTH_DEF);
        h = clamp_dim(cfg_height_q, MAX_HEIGHT);
        // Trailing odd column or row falls outside the active area and is dropped
        if (scan_col < 2 * (w / 2) && scan_row < 2 * (h / 2))
        begin
            slot = scan_col / 2;
            if (scan_col % 2 == 0)
                left_hold = pix;
            else if (scan_row % 2 == 0)
            begin
                for (int k = 0; k < NUM_CH; k++)
                    entry[k] = PAIR_W'(left_hold[k]) + PAIR_W'(pix[k]);
                pair_line[slot] = entry;
            end
            else
            begin
                entry = pair_line[slot];
                for (int k = 0; k < NUM_CH; k++)
                begin
                    quad = QUAD_W'(entry[k]) + QUAD_W'(left_hold[k]) + QUAD_W'(pix[k]);
                    res.rgba[k] = quad[QUAD_W-1:2];
                end
                res.last = (scan_row == 2 * (h / 2) - 1) && (scan_col == 2 * (w / 2) - 1);
                has_out  = 1'b1;
            end
        end
        // Wrap column, then row; the frame restarts after its last pixel
        scan_col++;
        if (scan_col >= w)
        begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= h)
                scan_row = 0;
        end
    endtask

    function automatic rgba_t random_pixel();
        rgba_t p;
        int    sel;
        for (int k = 0; k < NUM_CH; k++)
        begin
            sel = $urandom_range(9);
            // Lean on the channel extremes now and then
            if (sel == 0)
                p[k] = '0;
            else if (sel == 1)
                p[k] = '1;
            else
                p[k] = CH_W'($urandom_range(255));
        end
        return p;
    endfunction

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            MODE_RECV_HEAVY:
            begin
                send_idle_pct = 20;
                recv_idle_pct = 59;
            end
            MODE_SEND_HEAVY:
            begin
                send_idle_pct = 59;
                recv_idle_pct = 20;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one pixel; entered and left at a falling edge. Hold payload until accepted.
    task automatic send_pixel(input rgba_t pix, input bit typed, input reduced_t typed_want);
        bit       has_out;
        reduced_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= pix[0];
        green_in <= pix[1];
        blue_in  <= pix[2];
        alpha_in <= pix[3];
        do
            @(posedge clk);
        while (in_stall);
        predict_reduction(pix, has_out, res);
        // A hand-written expectation takes the place of the predicted one
        if (typed)
            expected_pixels.push_back(typed_want);
        else if (has_out)
            expected_pixels.push_back(res);
        @(negedge clk);
    endtask

    // Write one register once the block is idle; a write restarts the frame
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        // Let pixels that produce nothing work their way out
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == rbd_pkg::REG_SRC_WIDTH)
            cfg_width_q = int'(value);
        else
            cfg_height_q = int'(value);
        scan_col = 0;
        scan_row = 0;
    endtask

    // Configure both dimensions, then stream random pixels
    task automatic run_phase(input int w, input int h, input int count);
        write_register(rbd_pkg::REG_SRC_WIDTH, DIM_W'(w));
        write_register(rbd_pkg::REG_SRC_HEIGHT, DIM_W'(h));
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel(), 1'b0, '0);
    endtask

    task automatic add_pixel_row(input rgba_t pix, input bit typed, input reduced_t want);
        stim_row_t row;
        row        = '0;
        row.pix    = pix;
        row.typed  = typed;
        row.want   = want;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg_row(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = value;
        directed_rows.push_back(row);
    endtask

    function automatic void compare_field(input string name, input logic [CH_W-1:0] want,
                                          input logic [CH_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        reduced_t want;
        if (expected_pixels.size() == 0)
        begin
            $error("output pixel with no expectation waiting");
            fail_count++;
        end
        else
        begin
            want = expected_pixels.pop_front();
            compare_field("red_out",    want.rgba[0], red_out);
            compare_field("green_out",  want.rgba[1], green_out);
            compare_field("blue_out",   want.rgba[2], blue_out);
            compare_field("alpha_out",  want.rgba[3], alpha_out);
            compare_field("frame_last", CH_W'(want.last), CH_W'(frame_last));
        end
    endtask

    // Check every reduced pixel as it is taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
    end

    // Receiver: random stalls, plus one long hold-off on request to back the block up
    initial
    begin
        out_stall      = 1'b0;
        long_hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        int random_items;
        int w;
        int h;
        int area;
        int sel;
        int count;

        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        red_in        = '0;
        green_in      = '0;
        blue_in       = '0;
        alpha_in      = '0;
        long_hold_req = 1'b0;
        fail_count    = 0;
        random_items  = 0;
        cfg_width_q   = MAX_WIDTH_DEF;
        cfg_height_q  = MAX_HEIGHT;
        scan_col      = 0;
        scan_row      = 0;
        left_hold     = '0;
        set_idle_mode(MODE_RECV_HEAVY);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. At the reset size row 0 only fills the line store.
        add_pixel_row(32'hFFFFFFFF, 1'b0, '0);
        add_pixel_row(32'h00000000, 1'b0, '0);
        // Smallest image: every quad is a whole frame, so each result is the last one
        add_cfg_row(rbd_pkg::REG_SRC_WIDTH,  13'd2);
        add_cfg_row(rbd_pkg::REG_SRC_HEIGHT, 13'd2);
        repeat (4) add_pixel_row(32'hFFFFFFFF, 1'b0, '0);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].want  = {32'hFFFFFFFF, 1'b1};
        repeat (4) add_pixel_row(32'h00000000, 1'b0, '0);
        directed_rows[$].typed = 1'b1;
        directed_rows[$].want  = {32'h00000000, 1'b1};
        // Truncation: red 3/4 -> 0, green 1019/4 -> 254, blue 4/4 -> 1, alpha flat
        add_pixel_row(32'h8003FF01, 1'b0, '0);
        add_pixel_row(32'h8001FF01, 1'b0, '0);
        add_pixel_row(32'h8000FF01, 1'b0, '0);
        add_pixel_row(32'h8000FE00, 1'b1, {32'h8001FE00, 1'b1});
        // Odd trailing column and row are consumed with no output
        add_cfg_row(rbd_pkg::REG_SRC_WIDTH,  13'd3);
        add_cfg_row(rbd_pkg::REG_SRC_HEIGHT, 13'd3);
        add_pixel_row(32'h12345678, 1'b0, '0);
        add_pixel_row(32'h9ABCDEF0, 1'b0, '0);
        add_pixel_row(32'hFFFFFFFF, 1'b0, '0);
        add_pixel_row(32'h0F1E2D3C, 1'b0, '0);
        add_pixel_row(32'hC3A55A3C, 1'b0, '0);
        add_pixel_row(32'hFFFFFFFF, 1'b0, '0);
        add_pixel_row(32'hFFFFFFFF, 1'b0, '0);
        add_pixel_row(32'hFFFFFFFF, 1'b0, '0);
        add_pixel_row(32'hFFFFFFFF, 1'b0, '0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_register(directed_rows[i].idx, directed_rows[i].value);
            else
                send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random part: small images, whole frames plus a partial one, capped per phase; a third of the
        // items in each idle mode
        while (random_items < RANDOM_ITEMS)
        begin
            set_idle_mode(idle_mode_t'(random_items * 3 / RANDOM_ITEMS));
            sel = $urandom_range(9);
            if (sel == 0)
                w = $urandom_range(1);
            else if (sel == 1)
                w = $urandom_range(13, 40);
            else
                w = $urandom_range(2, 12);
            h = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
            area  = clamp_dim(w, MAX_WIDTH_DEF) * clamp_dim(h, MAX_HEIGHT);
            count = (area > 100 ? 1 : $urandom_range(1, 3)) * area
                    + $urandom_range(0, area - 1);
            if (count > RANDOM_ITEMS / 4)
                count = RANDOM_ITEMS / 4;
            if (count > RANDOM_ITEMS - random_items)
                count = RANDOM_ITEMS - random_items;
            run_phase(w, h, count);
            random_items += count;
        end

        // Back pressure: hold the output off long enough that the input stalls
        set_idle_mode(MODE_NO_IDLE);
        write_register(rbd_pkg::REG_SRC_WIDTH, DIM_W'(6));
        write_register(rbd_pkg::REG_SRC_HEIGHT, DIM_W'(4));
        long_hold_req = 1'b1;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
            send_pixel(random_pixel(), 1'b0, '0);

        // Extreme sizes: a height past the clamp, and a width past the clamp
        run_phase(2, 8191, 20);
        run_phase(8191, 3, 20);

        // Drain: wait for every expected pixel, then let the pipeline settle
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### files.f
sv/rbd_pkg.sv
sv/rbd_line_ram.sv
sv/rbd_scan.sv
sv/rgba_box_downsample_2x2.sv
dv/testbench.sv
